// File: rtl/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg: shared types and the decode function for the UTF-8 code point decoder
// Holds the pending byte buffer type, the controller/datapath signal groups
// and the function that judges the front of the pending buffer.
// ----------------------------------------------------------------------------
package ucd_pkg;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int CNT_W   = 3;
    localparam int DEPTH   = 4;

    // Replacement character '?'.
    localparam logic [CP_W-1:0] QMARK = 21'd63;

    // Lead byte masks and patterns.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    // Pending buffer: entry 0 is the oldest byte.
    typedef logic [DEPTH-1:0][BYTE_W-1:0] quad_t;

    // Outcome of judging the front of the buffer.
    typedef struct packed {
        logic             emit;
        logic [CP_W-1:0]  cp;
        logic [CNT_W-1:0] drop;
    } judge_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;
        logic step;
    } ucd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result;
        logic run_last;
        logic out_free;
    } ucd_stat_t;

    // Judge the front of the buffer: what to emit and how many bytes to drop.
    function automatic judge_t ucd_judge(input quad_t b, input logic [CNT_W-1:0] cnt,
                                         input logic last);
        judge_t           j;
        logic [7:0]       lead;
        logic [CNT_W-1:0] need;
        logic             ok;
        logic [CP_W-1:0]  cp;
        j    = '0;
        lead = b[0];
        need = '0;
        ok   = 1'b0;
        cp   = '0;
        if ((lead & LEAD2_MASK) == LEAD2_PAT) begin
            need = 3'd2;
        end else if ((lead & LEAD3_MASK) == LEAD3_PAT) begin
            need = 3'd3;
        end else if ((lead & LEAD4_MASK) == LEAD4_PAT) begin
            need = 3'd4;
        end
        ok = ((b[1] & CONT_MASK) == CONT_PAT)
            && ((need < 3'd3) || ((b[2] & CONT_MASK) == CONT_PAT))
            && ((need < 3'd4) || ((b[3] & CONT_MASK) == CONT_PAT));
        case (need)
            3'd2:    cp = {10'd0, lead[4:0], b[1][5:0]};
            3'd3:    cp = {5'd0, lead[3:0], b[1][5:0], b[2][5:0]};
            3'd4:    cp = {lead[2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: cp = '0;
        endcase
        if (cnt == '0) begin
            j = '0;
        end else if (!lead[7]) begin
            // Single-byte code point.
            j.emit = 1'b1;
            j.cp   = {13'd0, lead};
            j.drop = 3'd1;
        end else if (need == '0) begin
            // Not a valid lead byte.
            j.emit = 1'b1;
            j.cp   = QMARK;
            j.drop = 3'd1;
        end else if (cnt < need) begin
            // Sequence not complete: wait, or give up at the end of the text.
            if (last) begin
                j.emit = 1'b1;
                j.cp   = QMARK;
                j.drop = cnt;
            end
        end else if (ok) begin
            j.emit = 1'b1;
            j.cp   = cp;
            j.drop = need;
        end else begin
            // Bad continuation: reject the lead and rescan from the next byte.
            j.emit = 1'b1;
            j.cp   = QMARK;
            j.drop = 3'd1;
        end
        return j;
    endfunction

endpackage

// File: rtl/ucd_byte_if.sv
// ----------------------------------------------------------------------------
// ucd_byte_if: input byte channel
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
interface ucd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// File: rtl/ucd_cp_if.sv
// ----------------------------------------------------------------------------
// ucd_cp_if: output code point channel
// Valid/ready channel carrying one decoded code point and its run markers.
// ----------------------------------------------------------------------------
interface ucd_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        run_last;
    logic        text_end;

    modport source (output valid, output code_point, output run_last, output text_end,
                    input ready);
    modport sink   (input valid, input code_point, input run_last, input text_end,
                    output ready);
endinterface

// File: rtl/ucd_ctrl.sv
// ----------------------------------------------------------------------------
// ucd_ctrl: decoder controller
// Two-state machine: take one byte, then step the datapath once per result
// until the pending buffer yields nothing more.
// ----------------------------------------------------------------------------
module ucd_ctrl
    import ucd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ucd_stat_t stat,
    output ucd_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic state_reg;
    logic state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.append = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!stat.has_result) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.step = 1'b1;
                    if (stat.run_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/ucd_datapath.sv
// ----------------------------------------------------------------------------
// ucd_datapath: decoder datapath
// Pending byte buffer with its count, the front-of-buffer judge, a look-ahead
// judge that marks the last result of a byte, and the output register.
// ----------------------------------------------------------------------------
module ucd_datapath
    import ucd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ucd_cmd_t          cmd,
    output ucd_stat_t         stat,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              text_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CP_W-1:0]   code_point,
    output logic              run_last,
    output logic              text_end
);

    quad_t            pend_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             last_reg;
    logic             out_valid_reg;
    logic [CP_W-1:0]  cp_reg;
    logic             run_last_reg;
    logic             text_end_reg;

    judge_t           cur;
    judge_t           ahead;
    quad_t            pend_shift;
    logic [CNT_W-1:0] cnt_left;

    // Judge the front now, and what remains after this result is taken.
    always_comb
    begin
        cur        = ucd_judge(pend_reg, cnt_reg, last_reg);
        pend_shift = pend_reg >> {cur.drop, 3'b000};
        cnt_left   = cnt_reg - cur.drop;
        ahead      = ucd_judge(pend_shift, cnt_left, last_reg);
    end

    assign stat.has_result = cur.emit;
    assign stat.run_last   = !ahead.emit;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Pending buffer entries.
    always_ff @(posedge clk)
    begin
        if (cmd.append) begin
            pend_reg[cnt_reg[1:0]] <= text_byte;
            last_reg               <= text_last;
        end else if (cmd.step) begin
            pend_reg <= pend_shift;
        end
    end

    // Pending count; the buffer empties once the text has ended.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else if (cmd.append) begin
            cnt_reg <= cnt_reg + 3'd1;
        end else if (cmd.step) begin
            if (!ahead.emit && last_reg) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_left;
            end
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.step) begin
            cp_reg       <= cur.cp;
            run_last_reg <= !ahead.emit;
            text_end_reg <= !ahead.emit && last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign run_last   = run_last_reg;
    assign text_end   = text_end_reg;

endmodule

// File: rtl/utf8_codepoint_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit: UTF-8 to code point decoder
// Takes one text byte per transaction and returns the decoded code points,
// with '?' for bad leads, bad continuations and sequences cut off by the
// end of the text.
//
//   Channel   Dir  Payload                          Transaction
//   text_in   in   text_byte[7:0], text_last        valid & ready
//   cp_out    out  code_point[20:0], run_last,      valid & ready
//                  text_end
//
// A byte first enters the pending buffer; the controller then steps out
// one result it releases (zero to four) per cycle while the output register
// is free, and takes no new byte until the last such result is out.
// A byte that completes nothing still passes through evaluation.
// Reset clears the controller, the pending count and the output valid.
// A stalled output holds the decoder in evaluation until the register frees.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_unit
    import ucd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ucd_byte_if.sink text_in,
    ucd_cp_if.source cp_out
);

    ucd_cmd_t  cmd;
    ucd_stat_t stat;

    // Sequencing.
    ucd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_in.valid),
        .in_ready (text_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Buffer, judge and output register.
    ucd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .text_byte  (text_in.text_byte),
        .text_last  (text_in.text_last),
        .out_valid  (cp_out.valid),
        .out_ready  (cp_out.ready),
        .code_point (cp_out.code_point),
        .run_last   (cp_out.run_last),
        .text_end   (cp_out.text_end)
    );

endmodule

// File: tb/sv/utf8_codepoint_decoder_unit_checker.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit_checker: scoreboard for the UTF-8 decoder
// Watches the byte and code point channels, runs its own model of the
// pending byte buffer and compares every code point transaction, field by
// field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_unit_checker
    import ucd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ucd_byte_if  text_in,
    ucd_cp_if    cp_out,
    output int   mismatch_count,
    output int   results_waiting,
    output int   bytes_seen,
    output int   texts_seen,
    output int   points_seen,
    output int   qmarks_seen
);

    // One predicted code point transaction.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            run_last;
        logic            text_end;
    } cp_expect_t;

    cp_expect_t            expected_points[$];
    logic [BYTE_W-1:0]     held_bytes [DEPTH];
    logic [CNT_W-1:0]      held_count = '0;

    // Remove k bytes from the front of the held sequence.
    task automatic drop_front(input int k);
        if (k >= held_count)
        begin
            held_count = '0;
        end
        else
        begin
            for (int i = 0; i < DEPTH - k; i++)
            begin
                held_bytes[i] = held_bytes[i + k];
            end
            held_count = held_count - CNT_W'(k);
        end
    endtask

    // Append one byte, judge the held sequence and queue the code points it releases.
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [CP_W-1:0]   points [DEPTH];
        int                n;
        int                need;
        logic [BYTE_W-1:0] lead;
        logic [CP_W-1:0]   cp;
        bit                ok;
        bit                waiting;
        cp_expect_t        e;
        n       = 0;
        waiting = 1'b0;
        if (held_count > 3)
        begin
            held_count = '0;
        end
        held_bytes[held_count[1:0]] = b;
        held_count                  = held_count + 1'b1;

        while (held_count != 0 && n < DEPTH && !waiting)
        begin
            lead = held_bytes[0];
            need = 1;
            cp   = {13'd0, lead};
            // Classify the lead; a byte with the top bit set that is not a known lead is a '?'.
            if (lead[7])
            begin
                if (lead[7:5] == 3'b110)
                begin
                    need = 2;
                    cp   = {16'd0, lead[4:0]};
                end
                else if (lead[7:4] == 4'b1110)
                begin
                    need = 3;
                    cp   = {17'd0, lead[3:0]};
                end
                else if (lead[7:3] == 5'b11110)
                begin
                    need = 4;
                    cp   = {18'd0, lead[2:0]};
                end
                else
                begin
                    cp = QMARK;
                end
            end

            if (need == 1)
            begin
                points[n] = cp;
                n++;
                drop_front(1);
            end
            else if (held_count < need)
            begin
                // Incomplete: keep waiting, unless the text ends here.
                if (last)
                begin
                    points[n]  = QMARK;
                    n++;
                    held_count = '0;
                end
                waiting = 1'b1;
            end
            else
            begin
                ok = 1'b1;
                for (int i = 1; i < need; i++)
                begin
                    if (held_bytes[i][7:6] != 2'b10)
                    begin
                        ok = 1'b0;
                    end
                    cp = {cp[CP_W-7:0], held_bytes[i][5:0]};
                end
                if (ok)
                begin
                    points[n] = cp;
                    n++;
                    drop_front(need);
                end
                else
                begin
                    // Reject the lead only; the bytes after it are judged again.
                    points[n] = QMARK;
                    n++;
                    drop_front(1);
                end
            end
        end
        if (last)
        begin
            held_count = '0;
        end

        for (int k = 0; k < n; k++)
        begin
            e.cp       = points[k];
            e.run_last = (k == n - 1);
            e.text_end = (k == n - 1) && last;
            expected_points.push_back(e);
        end
    endtask

    // Predict on accepted bytes, then compare accepted code points.
    always @(posedge clk or negedge rst_n)
    begin
        cp_expect_t e;
        if (!rst_n)
        begin
            expected_points.delete();
            held_count      = '0;
            mismatch_count  <= 0;
            results_waiting <= 0;
            bytes_seen      <= 0;
            texts_seen      <= 0;
            points_seen     <= 0;
            qmarks_seen     <= 0;
        end
        else
        begin
            if (text_in.valid && text_in.ready)
            begin
                decode_byte(text_in.text_byte, text_in.text_last);
                bytes_seen <= bytes_seen + 1;
                if (text_in.text_last)
                begin
                    texts_seen <= texts_seen + 1;
                end
            end

            if (cp_out.valid && cp_out.ready)
            begin
                points_seen <= points_seen + 1;
                if (cp_out.code_point == QMARK)
                begin
                    qmarks_seen <= qmarks_seen + 1;
                end
                if (expected_points.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("MISMATCH: unexpected code point %06h run_last=%0b text_end=%0b",
                                 cp_out.code_point, cp_out.run_last, cp_out.text_end);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (cp_out.code_point !== e.cp || cp_out.run_last !== e.run_last
                        || cp_out.text_end !== e.text_end)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("MISMATCH: expected cp=%06h run_last=%0b text_end=%0b",
                                     e.cp, e.run_last, e.text_end);
                            $display("          got      cp=%06h run_last=%0b text_end=%0b",
                                     cp_out.code_point, cp_out.run_last, cp_out.text_end);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end

            results_waiting <= expected_points.size();
        end
    end

endmodule

// File: tb/sv/utf8_codepoint_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit_test: top level of the UTF-8 decoder testbench
// Drives directed byte sequences and then random texts made mostly of
// well-formed characters, with noise, broken and truncated sequences mixed
// in, under random idling on both channels. A checker beside the block
// scores the code points; this module gives the verdict.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_unit_test;
    import ucd_pkg::*;

    localparam int RANDOM_ITEMS = 135;
    localparam int CALM_ITEMS   = 30;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIRECTED   = 25;

    // Directed bytes as {text_last, text_byte}: ASCII extremes, each valid
    // form, bad leads, a bad continuation that releases four results, the
    // largest 4-byte value and a sequence cut off by the end of the text.
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0E2, 9'h082, 9'h0AC,
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF, 9'h0F8,
        9'h0F0, 9'h090, 9'h080, 9'h041, 9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF,
        9'h0E2, 9'h182, 9'h141
    };

    // Kinds of token in a random text.
    typedef enum int {TOK_CHAR, TOK_NOISE, TOK_BROKEN, TOK_STRAY} token_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ucd_byte_if text_in ();
    ucd_cp_if   cp_out ();

    logic       idle_enable;
    int         stall_left = 0;
    int         sent_count = 0;
    int         quiet_cycles = 0;
    logic [7:0] text_bytes[$];

    int mismatch_count;
    int results_waiting;
    int bytes_seen;
    int texts_seen;
    int points_seen;
    int qmarks_seen;

    always #1 clk = ~clk;

    utf8_codepoint_decoder_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text_in(text_in),
        .cp_out (cp_out)
    );

    utf8_codepoint_decoder_unit_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_in        (text_in),
        .cp_out         (cp_out),
        .mismatch_count (mismatch_count),
        .results_waiting(results_waiting),
        .bytes_seen     (bytes_seen),
        .texts_seen     (texts_seen),
        .points_seen    (points_seen),
        .qmarks_seen    (qmarks_seen)
    );

    // Receiver side: ready drops in random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cp_out.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            cp_out.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            cp_out.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 14);
        end
        else
        begin
            cp_out.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (text_in.valid && text_in.ready) || (cp_out.valid && cp_out.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, results_waiting);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, after an optional idle burst, and wait for its transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            text_in.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        text_in.valid     <= 1'b1;
        text_in.text_byte <= b;
        text_in.text_last <= last;
        @(posedge clk);
        while (!text_in.ready) @(posedge clk);
        sent_count++;
    endtask

    // Stop sending and wait until every predicted code point has been taken.
    task automatic wait_for_results();
        text_in.valid <= 1'b0;
        @(posedge clk);
        while (results_waiting != 0) @(posedge clk);
    endtask

    // Random lead byte of a 1 to 4 byte form.
    function automatic logic [7:0] lead_byte(input int form);
        logic [7:0] lb;
        case (form)
            1:       lb = 8'($urandom_range(0, 127));
            2:       lb = 8'hC0 | 8'($urandom_range(0, 31));
            3:       lb = 8'hE0 | 8'($urandom_range(0, 15));
            default: lb = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        return lb;
    endfunction

    // Append a lead of the given form followed by some continuation bytes.
    task automatic add_sequence(input int form, input int conts);
        logic [7:0] cb;
        text_bytes.push_back(lead_byte(form));
        for (int i = 0; i < conts; i++)
        begin
            cb = 8'h80 | 8'($urandom_range(0, 63));
            text_bytes.push_back(cb);
        end
    endtask

    // Build one random text into text_bytes.
    task automatic build_text();
        token_kind_t kind;
        int          r;
        int          form;
        logic [7:0]  nb;
        text_bytes.delete();
        repeat ($urandom_range(1, 10))
        begin
            r    = $urandom_range(0, 99);
            kind = (r < 70) ? TOK_CHAR : (r < 80) ? TOK_NOISE
                 : (r < 92) ? TOK_BROKEN : TOK_STRAY;
            form = $urandom_range(1, 4);
            case (kind)
                TOK_CHAR:
                begin
                    add_sequence(form, form - 1);
                end
                TOK_NOISE:
                begin
                    nb = 8'($urandom_range(0, 255));
                    text_bytes.push_back(nb);
                end
                TOK_BROKEN:
                begin
                    // A lead short of continuations, then a byte that is not one.
                    form = $urandom_range(2, 4);
                    add_sequence(form, $urandom_range(0, form - 2));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        nb = 8'($urandom_range(0, 127));
                    end
                    else
                    begin
                        nb = 8'hC0 | 8'($urandom_range(0, 63));
                    end
                    text_bytes.push_back(nb);
                end
                default:
                begin
                    nb = 8'h80 | 8'($urandom_range(0, 63));
                    text_bytes.push_back(nb);
                end
            endcase
        end
        // Sometimes the text ends in the middle of a sequence.
        if ($urandom_range(0, 99) < 15)
        begin
            form = $urandom_range(2, 4);
            add_sequence(form, $urandom_range(0, form - 2));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        bit paused;
        int n_bytes;
        paused = 1'b0;
        text_in.valid     <= 1'b0;
        text_in.text_byte <= '0;
        text_in.text_last <= 1'b0;
        idle_enable       <= 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        end

        // Random texts; one pause for a full drain halfway, no idling at the end.
        while (sent_count < N_DIRECTED + RANDOM_ITEMS)
        begin
            if (!paused && sent_count >= N_DIRECTED + RANDOM_ITEMS / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            if (sent_count < N_DIRECTED + RANDOM_ITEMS - CALM_ITEMS)
            begin
                idle_enable <= ($urandom_range(0, 3) != 0);
            end
            else
            begin
                idle_enable <= 1'b0;
            end
            build_text();
            n_bytes = text_bytes.size();
            for (int i = 0; i < n_bytes; i++)
            begin
                send_byte(text_bytes[i], i == n_bytes - 1);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d bytes in %0d texts, giving %0d code points (%0d of them '?').",
                 bytes_seen, texts_seen, points_seen, qmarks_seen);
        $display("Mismatches: %0d, results still outstanding: %0d.",
                 mismatch_count, results_waiting);
        if (mismatch_count == 0 && results_waiting == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
